@@ hw/rtl/alien_alphabet_order_topo_sort_top_defines.svh @@
// ----------------------------------------------------------------------------
// alien alphabet order: assertion macros
// shared assertion forms used by the sort sequencer
// ----------------------------------------------------------------------------
`ifndef ALIEN_ALPHABET_ORDER_TOPO_SORT_TOP_DEFINES_SVH
`define ALIEN_ALPHABET_ORDER_TOPO_SORT_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define AAOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AAOT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/aaot_pkg.sv @@
// ----------------------------------------------------------------------------
// aaot_pkg: shared types and constants
// sequencer states, control bundle and the ascii base letter
// ----------------------------------------------------------------------------
package aaot_pkg;

  // ascii code of the first letter of the alphabet
  localparam logic [6:0] BASE_CODE = 7'd97;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DFS,
    ST_CHECK,
    ST_EMIT,
    ST_BAD
  } aaot_state_t;

  // control from the sequencer to the word compare and matrix
  typedef struct packed {
    logic load;
    logic clear;
  } aaot_ctl_t;

endpackage

@@ hw/rtl/aaot_ffs.sv @@
// ----------------------------------------------------------------------------
// aaot_ffs: shared find-first-set unit
// lowest set bit of a letter mask, plus an any-set flag
// ----------------------------------------------------------------------------
module aaot_ffs #(
  parameter int N = 26
) (
  input  logic [N-1:0]         vec,
  output logic                 found,
  output logic [$clog2(N)-1:0] pos
);
  import aaot_pkg::*;

  localparam int IW = $clog2(N);

  logic [N-1:0] iso;

  // isolate the lowest set bit, then encode it
  assign iso   = vec & (~vec + N'(1));
  assign found = |vec;

  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      if (iso[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

endmodule

@@ hw/rtl/aaot_edge_mat.sv @@
// ----------------------------------------------------------------------------
// aaot_edge_mat: letter precedence matrix
// one row per letter, bit set for each letter known to follow it
// ----------------------------------------------------------------------------
module aaot_edge_mat #(
  parameter int N = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 set_en,
  input  logic [$clog2(N)-1:0] set_from,
  input  logic [$clog2(N)-1:0] set_to,
  input  logic [$clog2(N)-1:0] row_addr,
  output logic [N-1:0]         row
);
  import aaot_pkg::*;

  logic [N-1:0] mat_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < N; i++) begin
        mat_r[i] <= '0;
      end
    end else if (set_en) begin
      mat_r[set_from][set_to] <= 1'b1;
    end
  end

  // single read port, row chosen by the sequencer
  assign row = mat_r[row_addr];

endmodule

@@ hw/rtl/aaot_word_cmp.sv @@
// ----------------------------------------------------------------------------
// aaot_word_cmp: word loader and compare
// compares each letter with the previous word and flags the first difference
// ----------------------------------------------------------------------------
module aaot_word_cmp #(
  parameter int N       = 26,
  parameter int MAX_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [6:0]           in_char_code,
  input  logic                 in_word_end,
  input  logic                 in_list_end,
  input  aaot_pkg::aaot_ctl_t  ctl,
  output logic                 set_en,
  output logic [$clog2(N)-1:0] set_from,
  output logic [$clog2(N)-1:0] set_to
);
  import aaot_pkg::*;

  localparam int IW       = $clog2(N);
  localparam int PW       = $clog2(MAX_LEN + 1);
  localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CODE_LIM = int'(BASE_CODE) + N;

  logic [IW-1:0] mem [MAX_LEN];

  logic [6:0]    code_r;
  logic          wend_r;
  logic          lend_r;
  logic [IW-1:0] rd_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] plen_r, plen_nxt;
  logic          diff_r, diff_nxt;

  logic          ch_ok;
  logic [6:0]    code_off;
  logic [IW-1:0] cur;
  logic [PW-1:0] pos_adv;
  logic          w_done;

  // latch the beat and read the previous word's letter at this position
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_char_code;
      wend_r <= in_word_end;
      lend_r <= in_list_end;
      rd_r   <= mem[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ch_ok) begin
      mem[pos_r[AW-1:0]] <= cur;
    end
  end

  assign code_off = code_r - BASE_CODE;
  assign cur      = code_off[IW-1:0];
  assign ch_ok    = (code_r >= BASE_CODE) && (code_r < 7'(CODE_LIM))
                    && (pos_r < PW'(MAX_LEN));
  assign pos_adv  = ch_ok ? pos_r + PW'(1) : pos_r;
  assign w_done   = wend_r || lend_r;

  // first difference against the previous word sets one edge
  assign set_en   = ctl.load && ch_ok && !diff_r && (pos_r < plen_r)
                    && (rd_r != cur) && ({1'b0, rd_r} < (IW + 1)'(N));
  assign set_from = rd_r;
  assign set_to   = cur;

  always_comb begin
    pos_nxt  = pos_r;
    plen_nxt = plen_r;
    diff_nxt = diff_r;
    if (ctl.clear) begin
      pos_nxt  = '0;
      plen_nxt = '0;
      diff_nxt = 1'b0;
    end else if (ctl.load) begin
      if (w_done) begin
        pos_nxt  = '0;
        plen_nxt = pos_adv;
        diff_nxt = 1'b0;
      end else begin
        pos_nxt  = pos_adv;
        diff_nxt = diff_r | set_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      plen_r <= '0;
      diff_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      plen_r <= plen_nxt;
      diff_r <= diff_nxt;
    end
  end

endmodule

@@ hw/rtl/aaot_sort_ctrl.sv @@
// ----------------------------------------------------------------------------
// aaot_sort_ctrl: sort sequencer
// depth-first search, order check and result beats over the shared ffs unit
// ----------------------------------------------------------------------------
`include "alien_alphabet_order_topo_sort_top_defines.svh"

module aaot_sort_ctrl #(
  parameter int N = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 in_list_end,
  input  logic [N-1:0]         row,
  output logic [$clog2(N)-1:0] row_addr,
  output aaot_pkg::aaot_ctl_t  ctl,
  output logic                 busy,
  output logic                 out_strobe,
  output logic [6:0]           out_letter_code,
  output logic                 out_invalid,
  output logic                 out_last
);
  import aaot_pkg::*;

  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  aaot_state_t   state_r, state_nxt;

  logic          lend_r;
  logic [N-1:0]  visited_r, visited_nxt;
  logic [N-1:0]  seen_r, seen_nxt;
  logic [IW-1:0] stk_r [N];
  logic [IW-1:0] fin_r [N];
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] done_r, done_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  logic [6:0]    out_letter_r, out_letter_nxt;
  logic          out_invalid_r, out_invalid_nxt;
  logic          out_last_r, out_last_nxt;

  logic [N-1:0]  ffs_in;
  logic          ffs_found;
  logic [IW-1:0] ffs_pos;

  logic [CW-1:0] top_m1;
  logic [IW-1:0] top_node;
  logic [IW-1:0] fin_node;
  logic          stk_empty;
  logic          push;
  logic          pop;

  aaot_ffs #(.N(N)) u_ffs (
    .vec   (ffs_in),
    .found (ffs_found),
    .pos   (ffs_pos)
  );

  assign top_m1    = top_r - CW'(1);
  assign top_node  = stk_r[top_m1[IW-1:0]];
  assign fin_node  = fin_r[ptr_r];
  assign stk_empty = (top_r == '0);
  assign row_addr  = (state_r == ST_CHECK) ? fin_node : top_node;

  // shared unit input: next start, next unvisited neighbour, or back edge test
  always_comb begin
    case (state_r)
      ST_DFS:   ffs_in = stk_empty ? ~visited_r : (row & ~visited_r);
      ST_CHECK: ffs_in = row & seen_r;
      default:  ffs_in = '0;
    endcase
  end

  assign push = (state_r == ST_DFS) && ffs_found && (top_r < CW'(N));
  assign pop  = (state_r == ST_DFS) && !stk_empty && !push;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = lend_r ? ST_DFS : ST_IDLE;
      ST_DFS:   if (stk_empty && !ffs_found) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (ffs_found) begin
          state_nxt = ST_BAD;
        end else if (ptr_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT:  if (ptr_r == '0) state_nxt = ST_IDLE;
      ST_BAD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    ctl.load  = (state_r == ST_LOAD);
    ctl.clear = ((state_r == ST_EMIT) && (ptr_r == '0)) || (state_r == ST_BAD);
  end

  // datapath next values
  always_comb begin
    visited_nxt     = visited_r;
    seen_nxt        = seen_r;
    top_nxt         = top_r;
    done_nxt        = done_r;
    ptr_nxt         = ptr_r;
    out_strobe_nxt  = 1'b0;
    out_letter_nxt  = BASE_CODE;
    out_invalid_nxt = 1'b0;
    out_last_nxt    = 1'b0;
    if (push) begin
      visited_nxt = visited_r | (N'(1) << ffs_pos);
      top_nxt     = top_r + CW'(1);
    end
    if (pop) begin
      top_nxt = top_m1;
      if (done_r < CW'(N)) begin
        done_nxt = done_r + CW'(1);
      end
    end
    if ((state_r == ST_DFS) && (state_nxt == ST_CHECK)) begin
      ptr_nxt = IW'(N - 1);
    end
    if (state_r == ST_CHECK) begin
      seen_nxt = seen_r | (N'(1) << fin_node);
      ptr_nxt  = (ptr_r == '0) ? IW'(N - 1) : ptr_r - IW'(1);
    end
    if (state_r == ST_EMIT) begin
      ptr_nxt         = ptr_r - IW'(1);
      out_strobe_nxt  = 1'b1;
      out_letter_nxt  = BASE_CODE + 7'(fin_node);
      out_last_nxt    = (ptr_r == '0);
    end
    if (state_r == ST_BAD) begin
      out_strobe_nxt  = 1'b1;
      out_invalid_nxt = 1'b1;
      out_last_nxt    = 1'b1;
    end
    if (ctl.clear) begin
      visited_nxt = '0;
      seen_nxt    = '0;
      top_nxt     = '0;
      done_nxt    = '0;
      ptr_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      visited_r    <= '0;
      seen_r       <= '0;
      top_r        <= '0;
      done_r       <= '0;
      ptr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      visited_r    <= visited_nxt;
      seen_r       <= seen_nxt;
      top_r        <= top_nxt;
      done_r       <= done_nxt;
      ptr_r        <= ptr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lend_r <= in_list_end;
    end
    if (push) begin
      stk_r[top_r[IW-1:0]] <= ffs_pos;
    end
    if (pop && (done_r < CW'(N))) begin
      fin_r[done_r[IW-1:0]] <= top_node;
    end
    out_letter_r  <= out_letter_nxt;
    out_invalid_r <= out_invalid_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_letter_code = out_letter_r;
  assign out_invalid     = out_invalid_r;
  assign out_last        = out_last_r;

  // every visited letter is either on the stack or finished
  `AAOT_ASSERT_IMP(a_visit_count, 1'b1, $countones(visited_r) == int'(done_r) + int'(top_r), "visited letters do not match stack plus finished")
  // the search ends only once every letter has finished
  `AAOT_ASSERT_IMP(a_search_done, (state_r == ST_DFS) && (state_nxt == ST_CHECK), done_r == CW'(N), "search ended before all letters finished")
  // an invalid beat is always the only and final beat
  `AAOT_ASSERT_IMP(a_invalid_last, out_strobe_r && out_invalid_r, out_last_r, "invalid beat without last")
  // the final beat leaves the block ready
  `AAOT_ASSERT_IMP(a_last_idle, out_strobe_r && out_last_r, state_r == ST_IDLE, "final beat while still busy")
  // clearing empties the search state
  `AAOT_ASSERT_NXT(a_clear_empty, ctl.clear, (visited_r == '0) && (top_r == '0), "search state not cleared")

endmodule

@@ hw/rtl/alien_alphabet_order_topo_sort_top.sv @@
// ----------------------------------------------------------------------------
// alien alphabet order: top level
// derives a letter order from a sorted word list by depth-first search
// ----------------------------------------------------------------------------
// usage
//   input channel: one letter per beat on in_char_code with in_word_end and
//   in_list_end; a beat is taken on a rising edge with start high and busy low
//   letter beats: busy rises after each beat for the load step (letter compare
//   against the stored previous word, one memory read then one write)
//   list end: the beat with in_list_end set starts the sort; busy stays high
//   through the load, the search (one push or pop per cycle in the shared
//   find-first unit), the order check and ALPHABET_SIZE result beats at one
//   per cycle (or one invalid beat)
//   result channel: out_strobe marks each beat for exactly one cycle; results
//   are registered, in the cycle after the cycle that forms them; out_last marks
//   the final beat; the receiver cannot stall, results are never held back
//   after the final beat all run state is cleared and the block is idle
//   reset: synchronous active-low rst_n clears the matrix, counters and
//   sequencer; no result beat is pending after reset
// ----------------------------------------------------------------------------
module alien_alphabet_order_topo_sort_top #(
  parameter int MAX_WORD_LEN  = 32,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] in_char_code,
  input  logic       in_word_end,
  input  logic       in_list_end,
  output logic       out_strobe,
  output logic [6:0] out_letter_code,
  output logic       out_invalid,
  output logic       out_last
);
  import aaot_pkg::*;

  localparam int IW = $clog2(ALPHABET_SIZE);

  aaot_ctl_t            ctl;
  logic                 accept;
  logic                 set_en;
  logic [IW-1:0]        set_from;
  logic [IW-1:0]        set_to;
  logic [IW-1:0]        row_addr;
  logic [ALPHABET_SIZE-1:0] row;

  // a beat is taken only while the sequencer is idle
  assign accept = start && !busy;

  // letter loader: previous word memory and first-difference detect
  aaot_word_cmp #(
    .N       (ALPHABET_SIZE),
    .MAX_LEN (MAX_WORD_LEN)
  ) u_word_cmp (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_char_code (in_char_code),
    .in_word_end  (in_word_end),
    .in_list_end  (in_list_end),
    .ctl          (ctl),
    .set_en       (set_en),
    .set_from     (set_from),
    .set_to       (set_to)
  );

  // precedence matrix, one row read per cycle
  aaot_edge_mat #(
    .N (ALPHABET_SIZE)
  ) u_edge_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (ctl.clear),
    .set_en   (set_en),
    .set_from (set_from),
    .set_to   (set_to),
    .row_addr (row_addr),
    .row      (row)
  );

  // search, check and result sequencer
  aaot_sort_ctrl #(
    .N (ALPHABET_SIZE)
  ) u_sort_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_list_end     (in_list_end),
    .row             (row),
    .row_addr        (row_addr),
    .ctl             (ctl),
    .busy            (busy),
    .out_strobe      (out_strobe),
    .out_letter_code (out_letter_code),
    .out_invalid     (out_invalid),
    .out_last        (out_last)
  );

endmodule

@@ bench/alien_order_checker.sv @@
// ----------------------------------------------------------------------------
// alien alphabet order: result checker
// follows the letter beats into a private copy of the precedence matrix,
// derives the letter order at each list end and compares every result beat
// ----------------------------------------------------------------------------
module alien_order_checker #(
  parameter int MAX_LEN = 32,
  parameter int ALPHA   = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [6:0] in_char_code,
  input  logic       in_word_end,
  input  logic       in_list_end,
  input  logic       out_strobe,
  input  logic [6:0] out_letter_code,
  input  logic       out_invalid,
  input  logic       out_last,
  output int         fail_count,
  output int         pending,
  output int         beats_seen,
  output int         lists_seen,
  output int         order_beats,
  output int         contradictions
);
  import aaot_pkg::*;

  typedef struct packed {
    logic [6:0] letter;
    logic       bad;
    logic       fin;
  } order_beat_t;

  order_beat_t      order_due[$];
  logic [ALPHA-1:0] succ [ALPHA];
  logic [4:0]       prior_word [MAX_LEN];
  int               prior_len;
  int               cur_pos;
  bit               diff_seen;
  int               fails;
  int               n_beats;
  int               n_lists;
  int               n_order;
  int               n_bad;

  task automatic clear_run();
    for (int i = 0; i < ALPHA; i++) succ[i] = '0;
    prior_len = 0;
    cur_pos   = 0;
    diff_seen = 1'b0;
  endtask

  // append one predicted beat at the tail of the queue
  task automatic due_append(input order_beat_t beat);
    order_due.insert(order_due.size(), beat);
  endtask

  // dfs over the matrix, reverse finish order is the rank order
  task automatic derive_order();
    logic [ALPHA-1:0] seen;
    int               finish_ord [ALPHA];
    int               stk_node [ALPHA];
    int               stk_next [ALPHA];
    int               done;
    int               top;
    int               nd;
    int               t;
    int               a;
    bit               bad;
    order_beat_t      beat;
    seen = '0;
    done = 0;
    bad  = 1'b0;
    for (int s = 0; s < ALPHA; s++) begin
      if (!seen[s]) begin
        seen[s]     = 1'b1;
        stk_node[0] = s;
        stk_next[0] = 0;
        top         = 1;
        while (top > 0) begin
          nd = stk_node[top-1];
          t  = stk_next[top-1];
          while (t < ALPHA && !(succ[nd][t] && !seen[t])) t++;
          if (t < ALPHA && top < ALPHA) begin
            stk_next[top-1] = t + 1;
            seen[t]         = 1'b1;
            stk_node[top]   = t;
            stk_next[top]   = 0;
            top++;
          end else begin
            top--;
            if (done < ALPHA) begin
              finish_ord[done] = nd;
              done++;
            end
          end
        end
      end
    end
    // any edge from a later rank back to an earlier one means a cycle
    for (int i = 0; i < ALPHA && !bad; i++) begin
      a = finish_ord[ALPHA-1-i];
      for (int j = i + 1; j < ALPHA; j++)
        if (succ[finish_ord[ALPHA-1-j]][a]) bad = 1'b1;
    end
    if (bad) begin
      beat.letter = BASE_CODE;
      beat.bad    = 1'b1;
      beat.fin    = 1'b1;
      due_append(beat);
      n_bad++;
    end else begin
      for (int r = 0; r < ALPHA; r++) begin
        beat.letter = 7'(int'(BASE_CODE) + finish_ord[ALPHA-1-r]);
        beat.bad    = 1'b0;
        beat.fin    = (r == ALPHA - 1);
        due_append(beat);
      end
    end
  endtask

  task automatic take_beat(input logic [6:0] code, input logic wend, input logic lend);
    int ltr;
    ltr = int'(code) - int'(BASE_CODE);
    if (ltr >= 0 && ltr < ALPHA && cur_pos < MAX_LEN) begin
      if (!diff_seen && cur_pos < prior_len && int'(prior_word[cur_pos]) != ltr) begin
        succ[prior_word[cur_pos]][ltr] = 1'b1;
        diff_seen = 1'b1;
      end
      prior_word[cur_pos] = 5'(ltr);
      cur_pos++;
    end
    if (wend || lend) begin
      prior_len = cur_pos;
      cur_pos   = 0;
      diff_seen = 1'b0;
    end
    if (lend) begin
      derive_order();
      clear_run();
      n_lists++;
    end
  endtask

  task automatic check_beat();
    order_beat_t want;
    n_order++;
    if (order_due.size() == 0) begin
      $error("unexpected result beat: letter_code %0d invalid %0b last %0b",
             out_letter_code, out_invalid, out_last);
      fails++;
    end else begin
      want = order_due.pop_front();
      if (out_letter_code !== want.letter) begin
        $error("letter_code: expected %0d, got %0d", want.letter, out_letter_code);
        fails++;
      end
      if (out_invalid !== want.bad) begin
        $error("invalid: expected %0b, got %0b", want.bad, out_invalid);
        fails++;
      end
      if (out_last !== want.fin) begin
        $error("last: expected %0b, got %0b", want.fin, out_last);
        fails++;
      end
    end
  endtask

  initial begin
    fails   = 0;
    n_beats = 0;
    n_lists = 0;
    n_order = 0;
    n_bad   = 0;
    clear_run();
  end

  // results are compared before the beat of the same edge is absorbed
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      order_due.delete();
    end else begin
      if (out_strobe === 1'b1) check_beat();
      if (start && !busy) begin
        n_beats++;
        take_beat(in_char_code, in_word_end, in_list_end);
      end
    end
    fail_count     <= fails;
    pending        <= order_due.size();
    beats_seen     <= n_beats;
    lists_seen     <= n_lists;
    order_beats    <= n_order;
    contradictions <= n_bad;
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// alien alphabet order: testbench top
// feeds directed and random word lists into the sorter, mostly sorted lists
// over a shuffled alphabet with some broken lists and stray characters; a
// checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb;
  import aaot_pkg::*;

  localparam int MAX_LEN        = 32;
  localparam int ALPHA          = 26;
  localparam int ITEMS          = 210;
  localparam int WORD_CAP       = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       start        = 1'b0;
  logic [6:0] in_char_code = 7'd0;
  logic       in_word_end  = 1'b0;
  logic       in_list_end  = 1'b0;
  logic       busy;
  logic       out_strobe;
  logic [6:0] out_letter_code;
  logic       out_invalid;
  logic       out_last;

  int fail_count;
  int pending;
  int beats_seen;
  int lists_seen;
  int order_beats;
  int contradictions;

  // stimulus bookkeeping
  int idle_pct;
  int beats_sent;
  int directed_beats;
  int quiet_cycles;
  int phase;
  bit long_pending;
  // rank -> letter index of the alphabet used by the current list
  int rank_letter [ALPHA];
  // words held as ranks, the previous one is kept to build a sorted successor
  int prev_w [WORD_CAP];
  int prev_n;
  int cur_w [WORD_CAP];
  int cur_n;

  always #5 clk = ~clk;

  alien_alphabet_order_topo_sort_top #(
    .MAX_WORD_LEN (MAX_LEN),
    .ALPHABET_SIZE(ALPHA)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_word_end    (in_word_end),
    .in_list_end    (in_list_end),
    .out_strobe     (out_strobe),
    .out_letter_code(out_letter_code),
    .out_invalid    (out_invalid),
    .out_last       (out_last)
  );

  alien_order_checker #(
    .MAX_LEN(MAX_LEN),
    .ALPHA  (ALPHA)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_word_end    (in_word_end),
    .in_list_end    (in_list_end),
    .out_strobe     (out_strobe),
    .out_letter_code(out_letter_code),
    .out_invalid    (out_invalid),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .beats_seen     (beats_seen),
    .lists_seen     (lists_seen),
    .order_beats    (order_beats),
    .contradictions (contradictions)
  );

  // one beat: optional idle cycles first, then hold start until busy is low
  // at an edge; start is only ever assigned once per edge
  task automatic send_beat(input logic [6:0] code, input logic wend, input logic lend);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_char_code <= code;
    in_word_end  <= wend;
    in_list_end  <= lend;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  // a code outside the alphabet, low side or high side; the low side also
  // gives char bits 5 and 6 their zero values
  function automatic logic [6:0] noise_code();
    if ($urandom_range(3) == 0) return 7'($urandom_range(127, 123));
    return 7'($urandom_range(96));
  endfunction

  // sends cur_w; the closing beat of a list may or may not flag word end too
  task automatic send_word(input bit closes_list);
    logic wend;
    for (int i = 0; i < cur_n; i++) begin
      // stray characters inside a word are skipped by the block
      if ($urandom_range(15) == 0) send_beat(noise_code(), 1'b0, 1'b0);
      if (i == cur_n - 1) wend = closes_list ? 1'($urandom_range(1)) : 1'b1;
      else wend = 1'b0;
      send_beat(7'(int'(BASE_CODE) + rank_letter[cur_w[i]]), wend,
                closes_list && (i == cur_n - 1));
    end
  endtask

  // free word over the first k ranks; now and then longer than the length limit
  task automatic random_word(input int k);
    if (long_pending || $urandom_range(14) == 0) cur_n = $urandom_range(36, 33);
    else cur_n = $urandom_range(4, 1);
    long_pending = 1'b0;
    for (int i = 0; i < cur_n; i++) cur_w[i] = $urandom_range(k - 1);
  endtask

  // one word list; a sorted list keeps each word at or after the previous one
  // in rank order, a broken list is just random words
  task automatic send_list(input bit broken);
    int k;
    int nwords;
    int p;
    int j;
    int swap;
    int tail;
    // mostly few distinct letters so that edges chain up and cycles happen
    k = ($urandom_range(3) == 0) ? $urandom_range(26, 2) : $urandom_range(6, 2);
    for (int i = ALPHA - 1; i > 0; i--) begin
      j              = $urandom_range(i);
      swap           = rank_letter[i];
      rank_letter[i] = rank_letter[j];
      rank_letter[j] = swap;
    end
    nwords = $urandom_range(7, 1);
    prev_n = 0;
    for (int w = 0; w < nwords; w++) begin
      if (w == 0 || broken) begin
        random_word(k);
      end else begin
        // p is the first differing position; p == prev_n extends the word
        p = $urandom_range(prev_n);
        if (p < prev_n && prev_w[p] == k - 1) p = prev_n;
        for (int i = 0; i < p; i++) cur_w[i] = prev_w[i];
        if (p < prev_n) begin
          cur_w[p] = $urandom_range(k - 1, prev_w[p] + 1);
          cur_n    = p + 1;
          tail     = $urandom_range(3);
        end else begin
          cur_n = p;
          tail  = $urandom_range(2);
        end
        while (tail > 0 && cur_n < WORD_CAP) begin
          cur_w[cur_n] = $urandom_range(k - 1);
          cur_n++;
          tail--;
        end
      end
      // an empty word now and then: the next word then compares nothing
      if ($urandom_range(19) == 0) send_beat(noise_code(), 1'b1, 1'b0);
      send_word(w == nwords - 1);
      prev_w = cur_w;
      prev_n = cur_n;
    end
  endtask

  // watchdog: cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no beat moved for %0d cycles, %0d results still due", quiet_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    beats_sent   = 0;
    idle_pct     = 0;
    long_pending = 1'b1;
    for (int i = 0; i < ALPHA; i++) rank_letter[i] = i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: only the closing beat, with a stray char; z down to a back
    send_beat(7'd0, 1'b0, 1'b1);

    // "ab" "ba" "ab": a before b and b before a, a contradiction
    send_beat(7'd97, 1'b0, 1'b0);
    send_beat(7'd98, 1'b1, 1'b0);
    send_beat(7'd98, 1'b0, 1'b0);
    send_beat(7'd97, 1'b1, 1'b0);
    send_beat(7'd97, 1'b0, 1'b0);
    send_beat(7'd98, 1'b1, 1'b1);

    // empty first word, then "a" "za" "zz" "zzb" with stray chars on both
    // sides of the alphabet inside words; "zzb" after "zz" is a prefix case
    send_beat(7'h7f, 1'b1, 1'b0);
    send_beat(7'd97, 1'b1, 1'b0);
    send_beat(7'd122, 1'b0, 1'b0);
    send_beat(7'd96, 1'b0, 1'b0);
    send_beat(7'd97, 1'b1, 1'b0);
    send_beat(7'd122, 1'b0, 1'b0);
    send_beat(7'd123, 1'b0, 1'b0);
    send_beat(7'd122, 1'b1, 1'b0);
    send_beat(7'd122, 1'b0, 1'b0);
    send_beat(7'd122, 1'b0, 1'b0);
    send_beat(7'd98, 1'b1, 1'b0);
    // list closes on a stray char without word end
    send_beat(7'd0, 1'b0, 1'b1);

    // "z" then "a": z ranks first; the closing beat also flags word end
    send_beat(7'd122, 1'b1, 1'b0);
    send_beat(7'd97, 1'b1, 1'b1);
    directed_beats = beats_sent;

    // random lists in four idling phases: none, heavy, none, light
    while (beats_sent < ITEMS) begin
      phase = (beats_sent - directed_beats) * 4 / (ITEMS - directed_beats);
      case (phase)
        1:       idle_pct = 54;
        3:       idle_pct = 12;
        default: idle_pct = 0;
      endcase
      send_list($urandom_range(3) == 0);
    end
    start <= 1'b0;

    // one edge so the last list end is counted, then wait out the results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats in %0d word lists", beats_seen, lists_seen);
    $display("checked %0d order beats, %0d lists had a contradiction",
             order_beats, contradictions);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
